[rtl/kpsne_pkg.sv]
// ----------------------------------------------------------------------------
// Keypad scan numeric entry package
// Shared constants, phase codes, register indexes and the key character table.
// ----------------------------------------------------------------------------
package kpsne_pkg;

    localparam int unsigned COL_W   = 4;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned CODE_W  = 7;
    localparam int unsigned VALUE_W = 30;
    localparam int unsigned COUNT_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [COL_W-1:0]   COLS_ALL_HIGH = 4'hF;
    localparam logic [CODE_W-1:0]  ASCII_ZERO    = 7'd48;
    localparam logic [CODE_W-1:0]  ASCII_NINE    = 7'd57;
    localparam logic [CODE_W-1:0]  KEY_B         = 7'd66;
    localparam logic [CODE_W-1:0]  KEY_D         = 7'd68;
    localparam logic [COUNT_W-1:0] DIGIT_LIMIT   = 4'd9;

    // Scan phase codes; the spare code behaves as idle
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_SCAN = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BACKSPACE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIGITS       = 2'd1;

    // Reciprocal of ten, scaled by 2^35; exact floor for any 32-bit value
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int unsigned RECIP_SHIFT = 35;

    // Character table lookup: row and column of the pressed key
    function automatic logic [CODE_W-1:0] key_char(input logic [1:0] row,
                                                   input logic [1:0] col);
        logic [CODE_W-1:0] ch;
        case ({row, col})
            4'h0:    ch = 7'h31;  // 1
            4'h1:    ch = 7'h32;  // 2
            4'h2:    ch = 7'h33;  // 3
            4'h3:    ch = 7'h41;  // A
            4'h4:    ch = 7'h34;  // 4
            4'h5:    ch = 7'h35;  // 5
            4'h6:    ch = 7'h36;  // 6
            4'h7:    ch = 7'h42;  // B
            4'h8:    ch = 7'h37;  // 7
            4'h9:    ch = 7'h38;  // 8
            4'hA:    ch = 7'h39;  // 9
            4'hB:    ch = 7'h43;  // C
            4'hC:    ch = 7'h2A;  // *
            4'hD:    ch = 7'h30;  // 0
            4'hE:    ch = 7'h23;  // #
            default: ch = 7'h44;  // D
        endcase
        return ch;
    endfunction

    // Lowest low column among the first three, else the last column
    function automatic logic [1:0] first_low_col(input logic [COL_W-1:0] cols);
        logic [1:0] c;
        if (!cols[0]) begin
            c = 2'd0;
        end else if (!cols[1]) begin
            c = 2'd1;
        end else if (!cols[2]) begin
            c = 2'd2;
        end else begin
            c = 2'd3;
        end
        return c;
    endfunction

endpackage

[rtl/keypad_scan_numeric_entry.sv]
// ----------------------------------------------------------------------------
// Keypad scan numeric entry
// Steps a 4x4 active-low keypad scan one tick per item and keeps a decimal
// entry value that digits extend, B shortens and D completes.
// ----------------------------------------------------------------------------
// Path: an accepted item passes through the input register, then the result
//   register; the key decode and value update sit between them.
// Throughput: one item per cycle, back to back; while a result waits on
//   m_ready the input register takes one more item and then holds s_ready low.
// Reset: synchronous active-low aresetn clears the scan to idle, the value and
//   count to zero, backspace to enabled and the digit limit to nine.
module keypad_scan_numeric_entry (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [kpsne_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kpsne_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kpsne_pkg::COL_W-1:0]        s_col_levels,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [kpsne_pkg::ROW_W-1:0]        m_row_drive,
    output logic                               m_key_valid,
    output logic [kpsne_pkg::CODE_W-1:0]       m_key_code,
    output logic [kpsne_pkg::VALUE_W-1:0]      m_entry_value,
    output logic [kpsne_pkg::COUNT_W-1:0]      m_digit_count,
    output logic                               m_entry_done
);
    import kpsne_pkg::*;

    // Configuration
    logic               bs_enable_reg;
    logic [COUNT_W-1:0] max_digits_reg;

    // Input stage
    logic               in_valid_reg;
    logic [COL_W-1:0]   cols_reg;

    // Scan and entry state
    logic [1:0]         phase_reg, phase_next;
    logic [1:0]         row_reg, row_next;
    logic [VALUE_W-1:0] value_reg, value_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Result stage
    logic               out_valid_reg;
    logic [ROW_W-1:0]   drive_reg, drive_next;
    logic               kvalid_reg, kvalid_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [VALUE_W-1:0] shown_value_reg, shown_value_next;
    logic [COUNT_W-1:0] shown_count_reg, shown_count_next;
    logic               done_reg, done_next;

    logic               advance;
    logic               cols_idle;
    logic [COUNT_W-1:0] limit;
    logic               is_digit;
    logic [3:0]         digit;
    logic [VALUE_W-1:0] value_times_ten;
    logic [63:0]        div_prod;
    logic [VALUE_W-1:0] value_div_ten;
    logic [VALUE_W-1:0] value_upd;
    logic [COUNT_W-1:0] count_upd;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign cols_idle = (cols_reg == COLS_ALL_HIGH);
    assign limit     = (max_digits_reg > DIGIT_LIMIT) ? DIGIT_LIMIT : max_digits_reg;

    // Scan step
    always_comb begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        drive_next  = '0;
        kvalid_next = 1'b0;
        code_next   = '0;
        case (phase_reg)
            PH_SCAN: begin
                if (!cols_idle) begin
                    code_next   = key_char(row_reg, first_low_col(cols_reg));
                    kvalid_next = 1'b1;
                    phase_next  = PH_WAIT;
                end else if (row_reg == 2'd3) begin
                    // No key found on any row: back to idle
                    phase_next = PH_IDLE;
                    row_next   = 2'd0;
                end else begin
                    row_next   = row_reg + 2'd1;
                    drive_next = ~(ROW_W'(1) << (row_reg + 2'd1));
                end
            end
            PH_WAIT: begin
                if (cols_idle) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (!cols_idle) begin
                    row_next   = 2'd0;
                    phase_next = PH_SCAN;
                    drive_next = ~ROW_W'(1);
                end
            end
        endcase
    end

    // Entry arithmetic
    assign is_digit        = (code_next >= ASCII_ZERO) && (code_next <= ASCII_NINE);
    assign digit           = 4'(code_next - ASCII_ZERO);
    assign value_times_ten = (value_reg << 3) + (value_reg << 1) + VALUE_W'(digit);
    assign div_prod        = {34'd0, value_reg} * {32'd0, RECIP_TEN};
    assign value_div_ten   = VALUE_W'(div_prod >> RECIP_SHIFT);

    always_comb begin
        value_upd = value_reg;
        count_upd = count_reg;
        done_next = 1'b0;
        if (kvalid_next) begin
            if (is_digit) begin
                if (count_reg < limit) begin
                    value_upd = value_times_ten;
                    count_upd = count_reg + 4'd1;
                end
            end else if (code_next == KEY_B) begin
                if (bs_enable_reg && (count_reg != '0)) begin
                    value_upd = value_div_ten;
                    count_upd = count_reg - 4'd1;
                end
            end else if (code_next == KEY_D) begin
                done_next = 1'b1;
            end
        end
        shown_value_next = value_upd;
        shown_count_next = count_upd;
        // Clear the entry once D has shown it
        value_next = done_next ? '0 : value_upd;
        count_next = done_next ? '0 : count_upd;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_enable_reg  <= 1'b1;
            max_digits_reg <= DIGIT_LIMIT;
        end else if (cfg_we) begin
            if (cfg_index == CFG_BACKSPACE_ENABLE) begin
                bs_enable_reg <= cfg_wdata[0];
            end else if (cfg_index == CFG_MAX_DIGITS) begin
                max_digits_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cols_reg <= s_col_levels;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            row_reg   <= 2'd0;
            value_reg <= '0;
            count_reg <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            value_reg <= value_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            drive_reg       <= drive_next;
            kvalid_reg      <= kvalid_next;
            code_reg        <= code_next;
            shown_value_reg <= shown_value_next;
            shown_count_reg <= shown_count_next;
            done_reg        <= done_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_row_drive   = drive_reg;
    assign m_key_valid   = kvalid_reg;
    assign m_key_code    = code_reg;
    assign m_entry_value = shown_value_reg;
    assign m_digit_count = shown_count_reg;
    assign m_entry_done  = done_reg;

`ifndef SYNTHESIS
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DIGIT_LIMIT)
        else $error("digit count above nine");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && done_next |=> (count_reg == '0) && (value_reg == '0))
        else $error("entry not cleared after completion");

    a_decode_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && kvalid_next |=> (phase_reg == PH_WAIT))
        else $error("decoded key did not enter release wait");

    a_wait_no_key: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && (phase_reg == PH_WAIT) |-> !kvalid_next)
        else $error("key decoded while waiting for release");

    a_result_from_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without an accepted item");
`endif

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad scan numeric entry testbench
// Drives column samples as one item per scan tick and checks every result
// against a cycle-free predictor of the scan and entry logic. Key presses are
// well-formed scan sequences with random content, mixed with aborted scans
// and noise. Backspace and digit-limit settings are swept between phases.
// ----------------------------------------------------------------------------
module testbench;
    import kpsne_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SHOWN_LIMIT   = 10;

    // Writes to these indexes must not touch either register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [ROW_W-1:0]   rows;
        logic               key_valid;
        logic [CODE_W-1:0]  key_code;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digits;
        logic               done;
    } scan_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [COL_W-1:0]      s_col_levels;
    logic                  m_valid;
    logic                  m_ready;
    logic [ROW_W-1:0]      m_row_drive;
    logic                  m_key_valid;
    logic [CODE_W-1:0]     m_key_code;
    logic [VALUE_W-1:0]    m_entry_value;
    logic [COUNT_W-1:0]    m_digit_count;
    logic                  m_entry_done;

    // Predictor state and register copies
    logic [1:0]         kp_phase;
    logic [1:0]         kp_row;
    logic [VALUE_W-1:0] entry_acc;
    logic [COUNT_W-1:0] entry_digits;
    logic               backspace_on;
    logic [COUNT_W-1:0] digit_cap;
    string              key_chars = "123A456B789C*0#D";

    scan_result_t results_due[$];
    int           error_count = 0;
    int           items_sent  = 0;
    bit           idling_on   = 1'b1;

    keypad_scan_numeric_entry u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_col_levels  (s_col_levels),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_drive   (m_row_drive),
        .m_key_valid   (m_key_valid),
        .m_key_code    (m_key_code),
        .m_entry_value (m_entry_value),
        .m_digit_count (m_digit_count),
        .m_entry_done  (m_entry_done)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Advance the scan and entry state by one tick
    function automatic scan_result_t scan_tick(input logic [COL_W-1:0] cols);
        scan_result_t       r;
        logic [1:0]         col;
        logic [7:0]         ch;
        logic [COUNT_W-1:0] cap;
        r = '0;
        case (kp_phase)
            PH_SCAN: begin
                if (cols != COLS_ALL_HIGH) begin
                    col = 2'd3;
                    for (int c = 2; c >= 0; c--) begin
                        if (!cols[c]) col = 2'(c);
                    end
                    ch = key_chars[{kp_row, col}];
                    r.key_valid = 1'b1;
                    r.key_code  = ch[CODE_W-1:0];
                    kp_phase    = PH_WAIT;
                end else if (kp_row == 2'd3) begin
                    kp_phase = PH_IDLE;
                    kp_row   = 2'd0;
                end else begin
                    kp_row = kp_row + 2'd1;
                    r.rows = ~(4'b0001 << kp_row);
                end
            end
            PH_WAIT: begin
                if (cols == COLS_ALL_HIGH) kp_phase = PH_IDLE;
            end
            default: begin
                kp_phase = PH_IDLE;
                if (cols != COLS_ALL_HIGH) begin
                    kp_row   = 2'd0;
                    kp_phase = PH_SCAN;
                    r.rows   = 4'b1110;
                end
            end
        endcase

        if (r.key_valid) begin
            cap = (digit_cap > DIGIT_LIMIT) ? DIGIT_LIMIT : digit_cap;
            if (r.key_code >= ASCII_ZERO && r.key_code <= ASCII_NINE) begin
                if (entry_digits < cap) begin
                    entry_acc    = VALUE_W'(entry_acc * 10 + (r.key_code - ASCII_ZERO));
                    entry_digits = entry_digits + 4'd1;
                end
            end else if (r.key_code == KEY_B) begin
                if (backspace_on && entry_digits != 0) begin
                    entry_acc    = entry_acc / 10;
                    entry_digits = entry_digits - 4'd1;
                end
            end else if (r.key_code == KEY_D) begin
                r.done = 1'b1;
            end
        end
        r.value  = entry_acc;
        r.digits = entry_digits;
        if (r.done) begin
            entry_acc    = '0;
            entry_digits = '0;
        end
        return r;
    endfunction

    // Send one column sample; returns at the edge that accepts it
    task automatic push_cols(input logic [COL_W-1:0] cols);
        if (idling_on && $urandom_range(0, 9) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_col_levels <= cols;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        results_due.push_back(scan_tick(cols));
    endtask

    // Stop sending and hold until every result is back
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        if (idx == CFG_BACKSPACE_ENABLE) begin
            backspace_on = data[0];
        end else if (idx == CFG_MAX_DIGITS) begin
            digit_cap = data;
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Full press: start tick, quiet rows, the hit row, hold ticks, release
    task automatic press_key(input logic [1:0] row, input logic [1:0] col, input int hold);
        logic [COL_W-1:0] pat;
        push_cols(COL_W'($urandom_range(0, 14)));
        for (int r = 0; r < row; r++) push_cols(COLS_ALL_HIGH);
        pat      = COL_W'($urandom_range(0, 15)) | ((4'b0001 << col) - 4'b0001);
        pat[col] = 1'b0;
        push_cols(pat);
        repeat (hold) push_cols(COL_W'($urandom_range(0, 14)));
        push_cols(COLS_ALL_HIGH);
    endtask

    // Scan that walks all four rows and finds nothing
    task automatic empty_scan();
        push_cols(COL_W'($urandom_range(0, 14)));
        repeat (4) push_cols(COLS_ALL_HIGH);
    endtask

    task automatic key_traffic(input int count);
        int goal;
        int pick;
        goal = items_sent + count;
        while (items_sent < goal) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                empty_scan();
            end else if (pick < 18) begin
                repeat ($urandom_range(1, 3)) push_cols(COL_W'($urandom_range(0, 15)));
            end else begin
                press_key(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          $urandom_range(0, 3));
            end
        end
    endtask

    task automatic run_setting(input logic bs, input logic [CFG_DATA_W-1:0] cap, input int count);
        drain_results();
        write_reg(CFG_BACKSPACE_ENABLE, {3'($urandom_range(0, 7)), bs});
        write_reg(CFG_MAX_DIGITS, cap);
        key_traffic(count);
    endtask

    task automatic test_directed_keys();
        press_key(2'd1, 2'd3, 0);   // backspace with nothing held
        press_key(2'd0, 2'd0, 1);   // digit 1
        empty_scan();
        press_key(2'd3, 2'd1, 0);   // digit 0
        press_key(2'd3, 2'd3, 0);   // complete the entry
    endtask

    task automatic test_limit_lowered();
        run_setting(1'b1, 4'd9, 0);
        repeat (6) press_key(2'($urandom_range(0, 2)), 2'($urandom_range(0, 2)), 0);
        drain_results();
        write_reg(CFG_MAX_DIGITS, 4'd2);
        repeat (2) press_key(2'd2, 2'd2, 0);
        repeat (3) press_key(2'd1, 2'd3, 0);
        press_key(2'd3, 2'd1, 0);
        press_key(2'd3, 2'd3, 0);
    endtask

    task automatic test_config_sweep();
        run_setting(1'b0, 4'd9, 120);
        run_setting(1'b1, 4'd0, 120);
        idling_on = 1'b0;
        run_setting(1'b1, 4'd1, 120);
        idling_on = 1'b1;
        run_setting(1'b0, 4'd15, 120);
        run_setting(1'b1, 4'd4, 120);
        drain_results();
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom_range(0, 15)));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom_range(0, 15)));
        key_traffic(120);
    endtask

    task automatic test_random_traffic();
        run_setting(1'b1, 4'd9, 400);
        idling_on = 1'b0;
        key_traffic(200);
    endtask

    // Result sink: random stall bursts while idling is on
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (idling_on && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        scan_result_t got;
        scan_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_row_drive, m_key_valid, m_key_code, m_entry_value,
                    m_digit_count, m_entry_done};
            if (results_due.size() == 0) begin
                error_count++;
                if (error_count <= SHOWN_LIMIT) begin
                    $display("unexpected result: rows=%h key=%b/%h value=%0d digits=%0d done=%b",
                             got.rows, got.key_valid, got.key_code, got.value,
                             got.digits, got.done);
                end
            end else begin
                want = results_due.pop_front();
                if (got.rows !== want.rows || got.key_valid !== want.key_valid ||
                    got.key_code !== want.key_code || got.value !== want.value ||
                    got.digits !== want.digits || got.done !== want.done) begin
                    error_count++;
                    if (error_count <= SHOWN_LIMIT) begin
                        $display("mismatch: want rows=%h key=%b/%h value=%0d digits=%0d done=%b",
                                 want.rows, want.key_valid, want.key_code, want.value,
                                 want.digits, want.done);
                        $display("          got  rows=%h key=%b/%h value=%0d digits=%0d done=%b",
                                 got.rows, got.key_valid, got.key_code, got.value,
                                 got.digits, got.done);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge aclk);
        $display("testbench: errors");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BACKSPACE_ENABLE;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_col_levels = COLS_ALL_HIGH;
        kp_phase     = PH_IDLE;
        kp_row       = 2'd0;
        entry_acc    = '0;
        entry_digits = '0;
        backspace_on = 1'b1;
        digit_cap    = DIGIT_LIMIT;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_keys();
        test_limit_lowered();
        test_config_sweep();
        test_random_traffic();
        drain_results();

        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/kpsne_pkg.sv
rtl/keypad_scan_numeric_entry.sv
dv/testbench.sv
